[src/kti_pkg.sv]
// Shared constants and types for the keyframe track interpolator.
`timescale 1ns / 1ps
`default_nettype none
package kti_pkg;

	// Track geometry
	localparam int MAX_KEYS = 64;
	localparam int KEY_AW   = $clog2(MAX_KEYS);

	// Field widths
	localparam int CNT_W    = 7;
	localparam int TIME_W   = 32;
	localparam int VAL_W    = 32;
	localparam int FRAC_W   = 16;
	localparam int FACT_W   = 17;
	localparam int SEG_W    = 6;
	localparam int VEC_W    = 3 * VAL_W;

	// Stream widths
	localparam int S_DATA_W = 168;
	localparam int M_DATA_W = 120;

	// Register map
	localparam int        PADDR_W       = 3;
	localparam logic      REG_KEY_COUNT = 1'b0;
	localparam logic [CNT_W-1:0] KEY_COUNT_RST = 7'd1;

	// Item kinds carried on tuser
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Factor of one in 1.16 format
	localparam logic [FACT_W-1:0] ONE_Q16 = 17'h10000;

endpackage
`default_nettype wire

[src/keyframe_track_interpolator.sv]
// Keyframe track store with linear interpolation between keyframes.
//
//  Channel  Dir  Handshake               Payload
//  s_*      in   s_tvalid / s_tready     tuser: op; tdata: key and query fields
//  m_*      out  m_tvalid / m_tready     tdata: interpolated value, segment, factor
//  APB      in   psel, penable, pwrite   key_count at byte address 0
//
// A write beat stores its key when it is accepted. A query tests the last key,
// then if needed scans key times one per cycle through the time memory read
// port and runs restoring division for the factor; it then reads the two value
// memory words and runs the shared multiply/add for each component.
// Reset sets key_count to one and clears the sequencer, working and output registers; key memories hold no reset.
// The block takes one beat at a time; a finished result waits in the output
// register, and the next beat is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none
module keyframe_track_interpolator import kti_pkg::*; (
	input  wire                    clk,
	input  wire                    arst_n,
	// tuser: op
	input  wire                    s_tvalid,
	output logic                   s_tready,
	input  wire  [0:0]             s_tuser,
	// tdata: key_index[5:0], key_time[37:6], key_x[69:38], key_y[101:70],
	//        key_z[133:102], query_time[165:134], zero pad
	input  wire  [S_DATA_W-1:0]    s_tdata,
	output logic                   m_tvalid,
	input  wire                    m_tready,
	// tdata: out_x[31:0], out_y[63:32], out_z[95:64], segment[101:96],
	//        blend_factor[118:102], zero pad
	output logic [M_DATA_W-1:0]    m_tdata,
	input  wire                    psel,
	input  wire                    penable,
	input  wire                    pwrite,
	input  wire  [PADDR_W-1:0]     paddr,
	input  wire  [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_LAST_RD, ST_LAST_CHK, ST_SCAN, ST_SETUP, ST_DIV,
		ST_VA, ST_VB, ST_VC, ST_MUL, ST_ADD, ST_DONE
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     key_count_q;
	logic [KEY_AW-1:0]    last;

	// Key memories
	logic [TIME_W-1:0]    tmem [MAX_KEYS];
	logic [VEC_W-1:0]     vmem [MAX_KEYS];
	logic [TIME_W-1:0]    tm_rd;
	logic [VEC_W-1:0]     vm_rd;
	logic [KEY_AW-1:0]    tm_raddr;
	logic [KEY_AW-1:0]    vm_raddr;

	// Query working registers
	logic [TIME_W-1:0]    t_q;
	logic [KEY_AW:0]      iss_q;
	logic                 rd_vld_q;
	logic [KEY_AW-1:0]    rd_idx_q;
	logic [TIME_W-1:0]    prev_q;
	logic [TIME_W-1:0]    start_q;
	logic [TIME_W-1:0]    end_q;
	logic [KEY_AW-1:0]    seg_q;
	logic [KEY_AW-1:0]    nxt_q;
	logic [TIME_W-1:0]    rem_q;
	logic [TIME_W-1:0]    len_q;
	logic [3:0]           cnt_q;
	logic [FACT_W-1:0]    fq_q;
	logic [VEC_W-1:0]     a_q;
	logic [VEC_W-1:0]     b_q;
	logic [1:0]           comp_q;
	logic signed [50:0]   prod_s1;
	logic [VEC_W-1:0]     res_q;
	logic [M_DATA_W-1:0]  m_tdata_q;
	logic                 m_tvalid_q;

	logic                 s_fire;
	logic                 cfg_wr;
	logic                 out_load;
	logic [TIME_W:0]      rem_sh;
	logic [VAL_W-1:0]     a_k;
	logic [VAL_W-1:0]     b_k;
	logic signed [VAL_W:0] diff_k;

	assign s_tready = (state_q == ST_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_KEY_COUNT);

	// A finished result enters the output register once it is free or being taken.
	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// Register read-back
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_KEY_COUNT) begin
			prdata = {{(32 - CNT_W){1'b0}}, key_count_q};
		end
	end

	// Index of the last key in use, with the count held to 1..MAX_KEYS.
	always_comb begin
		if (key_count_q == '0) begin
			last = '0;
		end else if (key_count_q > CNT_W'(MAX_KEYS)) begin
			last = KEY_AW'(MAX_KEYS - 1);
		end else begin
			last = KEY_AW'(key_count_q - CNT_W'(1));
		end
	end

	// Read addresses for both memories.
	always_comb begin
		tm_raddr = iss_q[KEY_AW-1:0];
		if (state_q == ST_LAST_RD) begin
			tm_raddr = last;
		end
		vm_raddr = seg_q;
		if (state_q == ST_VB) begin
			vm_raddr = nxt_q;
		end
	end

	// Time memory: written by write beats, read one key per cycle.
	always_ff @(posedge clk) begin
		if (s_fire && s_tuser[0] == OP_WRITE) begin
			tmem[s_tdata[KEY_AW-1:0]] <= s_tdata[37:6];
		end
		tm_rd <= tmem[tm_raddr];
	end

	// Value memory holds z, y, x packed from the top down.
	always_ff @(posedge clk) begin
		if (s_fire && s_tuser[0] == OP_WRITE) begin
			vmem[s_tdata[KEY_AW-1:0]] <= s_tdata[133:38];
		end
		vm_rd <= vmem[vm_raddr];
	end

	// One restoring division step and the current component operands.
	always_comb begin
		rem_sh = {rem_q, 1'b0};
		a_k    = a_q[comp_q * VAL_W +: VAL_W];
		b_k    = b_q[comp_q * VAL_W +: VAL_W];
		diff_k = $signed({b_k[VAL_W-1], b_k}) - $signed({a_k[VAL_W-1], a_k});
	end

	// Query sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_count_q <= KEY_COUNT_RST;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			iss_q       <= '0;
			rd_vld_q    <= 1'b0;
			rd_idx_q    <= '0;
			cnt_q       <= '0;
			comp_q      <= '0;
			t_q         <= '0;
			prev_q      <= '0;
			start_q     <= '0;
			end_q       <= '0;
			seg_q       <= '0;
			nxt_q       <= '0;
			rem_q       <= '0;
			len_q       <= '0;
			fq_q        <= '0;
			a_q         <= '0;
			b_q         <= '0;
			prod_s1     <= '0;
			res_q       <= '0;
		end else begin
			if (cfg_wr) begin
				key_count_q <= pwdata[CNT_W-1:0];
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_fire && s_tuser[0] == OP_QUERY) begin
						t_q     <= s_tdata[165:134];
						state_q <= ST_LAST_RD;
					end
				end
				ST_LAST_RD: begin
					state_q <= ST_LAST_CHK;
				end
				// Single key, or at or past the last key: use the last key as is.
				ST_LAST_CHK: begin
					if (last == '0 || t_q >= tm_rd) begin
						seg_q   <= last;
						nxt_q   <= last;
						fq_q    <= '0;
						state_q <= ST_VA;
					end else begin
						iss_q    <= '0;
						rd_vld_q <= 1'b0;
						state_q  <= ST_SCAN;
					end
				end
				// Stream key times; stop at the first end time later than t.
				ST_SCAN: begin
					iss_q    <= iss_q + 1'b1;
					rd_vld_q <= 1'b1;
					rd_idx_q <= iss_q[KEY_AW-1:0];
					if (rd_vld_q) begin
						prev_q <= tm_rd;
						if (rd_idx_q != '0 && t_q < tm_rd) begin
							seg_q   <= rd_idx_q - 1'b1;
							nxt_q   <= rd_idx_q;
							start_q <= prev_q;
							end_q   <= tm_rd;
							state_q <= ST_SETUP;
						end
					end
				end
				ST_SETUP: begin
					fq_q  <= '0;
					cnt_q <= '0;
					if (end_q > start_q && t_q >= start_q) begin
						rem_q   <= t_q - start_q;
						len_q   <= end_q - start_q;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_VA;
					end
				end
				// One quotient bit per cycle; the offset is below the length.
				ST_DIV: begin
					if (rem_sh >= {1'b0, len_q}) begin
						rem_q <= TIME_W'(rem_sh - {1'b0, len_q});
						fq_q  <= {fq_q[FACT_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[TIME_W-1:0];
						fq_q  <= {fq_q[FACT_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'(FRAC_W - 1)) begin
						state_q <= ST_VA;
					end
				end
				ST_VA: begin
					state_q <= ST_VB;
				end
				ST_VB: begin
					a_q     <= vm_rd;
					state_q <= ST_VC;
				end
				ST_VC: begin
					b_q     <= vm_rd;
					comp_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_s1 <= diff_k * $signed({1'b0, fq_q});
					state_q <= ST_ADD;
				end
				// The arithmetic shift of the product rounds toward minus infinity.
				ST_ADD: begin
					res_q[comp_q * VAL_W +: VAL_W] <= a_k + prod_s1[FRAC_W +: VAL_W];
					if (comp_q == 2'd2) begin
						state_q <= ST_DONE;
					end else begin
						comp_q  <= comp_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						m_tdata_q  <= {1'b0, fq_q, SEG_W'(seg_q), res_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The factor never exceeds one.
	a_factor_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[118:102] <= ONE_Q16))
		else $error("blend factor above one");

	// The division remainder stays below the segment length.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < len_q))
		else $error("division remainder not below length");

	// The chosen segment never runs past the last key in use.
	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_VA) |-> (nxt_q <= last && seg_q <= nxt_q))
		else $error("segment beyond last key");

	// An accepted query starts with the read of the last key.
	a_query_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && s_tuser[0] == OP_QUERY) |=> (state_q == ST_LAST_RD))
		else $error("query did not start");

endmodule
`default_nettype wire
